>>> hw/rtl/i2cmrt_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the I2C register transfer master.
package i2cmrt_pkg;

    typedef enum logic [13:0] {
        PH_INIT     = 14'b00000000000001,
        PH_IDLE     = 14'b00000000000010,
        PH_START    = 14'b00000000000100,
        PH_ADDR     = 14'b00000000001000,
        PH_REGH     = 14'b00000000010000,
        PH_REGL     = 14'b00000000100000,
        PH_RESTART  = 14'b00000001000000,
        PH_RADDR    = 14'b00000010000000,
        PH_RDATA    = 14'b00000100000000,
        PH_WDATA    = 14'b00001000000000,
        PH_STOP     = 14'b00010000000000,
        PH_PAUSE    = 14'b00100000000000,
        PH_DONE_OK  = 14'b01000000000000,
        PH_DONE_ERR = 14'b10000000000000
    } phase_t;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_BUSY     = 2'd1;
    localparam logic [1:0] ST_DONE_OK  = 2'd2;
    localparam logic [1:0] ST_DONE_ERR = 2'd3;

    localparam logic CFG_PAUSE   = 1'b0;
    localparam logic CFG_STRETCH = 1'b1;

    localparam logic [15:0] PAUSE_RESET   = 16'd5000;
    localparam logic [15:0] STRETCH_RESET = 16'd200;

    // write port and prefetch read port of the data buffer
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [8:0] raddr;
    } buf_req_t;

endpackage

>>> hw/rtl/i2cmrt_wbuf.sv
`timescale 1ns / 1ps
// Write data buffer: synchronous memory with write-to-read forwarding.
module i2cmrt_wbuf
    import i2cmrt_pkg::*;
#(
    parameter int BUF_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  buf_req_t   req,
    output logic [7:0] rdata
);
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    logic [7:0] mem [BUF_DEPTH];
    logic [7:0] q_reg;
    logic       w_ok;
    logic       r_ok;
    logic       fwd_hit_reg;
    logic       fwd_hit_next;
    logic [7:0] fwd_data_reg;
    logic       inr_reg;

    assign w_ok = req.we && ({1'b0, req.waddr} < 9'(BUF_DEPTH));
    assign r_ok = req.raddr < 9'(BUF_DEPTH);
    assign fwd_hit_next = w_ok && ({1'b0, req.waddr} == req.raddr);

    always_ff @(posedge clk)
    begin
        if (w_ok)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        q_reg <= mem[req.raddr[AW-1:0]];
        fwd_data_reg <= req.wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
            inr_reg     <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
            inr_reg     <= r_ok;
        end
    end

    // positions beyond the buffer read as zero
    assign rdata = !inr_reg ? 8'd0 : (fwd_hit_reg ? fwd_data_reg : q_reg);

endmodule

>>> hw/rtl/i2c_master_register_transfer.sv
`timescale 1ns / 1ps
// Top level: I2C master sequencer for register reads and writes.
//
//  channel | signals                          | direction
//  in      | in_valid/in_ready + 10 fields    | request words in
//  out     | out_valid/out_ready + 9 fields   | one status word per request word
//  cfg     | cfg_write, cfg_index, cfg_data   | register writes, no wait
//
// One word a cycle: each word is one sequencer step, registered into the output stage.
// A new word is taken while the output stage is empty or being read the same cycle.
// The data buffer is prefetched through its registered read port at the next send position.
// Reset starts the bus release sequence; the line state comes up released, the output drives are not reset.
module i2c_master_register_transfer
    import i2cmrt_pkg::*;
#(
    parameter int BUF_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic        scl_in,
    input  logic        sda_in,
    input  logic [7:0]  slave_addr,
    input  logic [15:0] reg_addr,
    input  logic        reg_addr_two,
    input  logic [7:0]  byte_count,
    input  logic        is_read,
    input  logic [7:0]  write_index,
    input  logic [7:0]  write_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_drive,
    output logic        sda_drive,
    output logic [1:0]  bus_status,
    output logic        begin_accepted,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic [7:0]  read_index,
    output logic [7:0]  error_count,
    output logic        line_power
);
    logic [15:0] pause_reg, stretch_reg;
    phase_t      phase_reg, phase_next;
    logic [2:0]  slot_reg, slot_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  err_reg, err_next;
    logic [15:0] wait_reg, wait_next;
    logic [7:0]  req_sa_reg, req_sa_next;
    logic [15:0] req_ra_reg, req_ra_next;
    logic        req_two_reg, req_two_next;
    logic [7:0]  req_bc_reg, req_bc_next;
    logic        req_rd_reg, req_rd_next;
    logic        power_reg, power_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;

    logic        ov_reg;
    logic        o_scl_reg, o_sda_reg, o_beg_reg, o_rv_reg, o_pw_reg;
    logic [1:0]  o_st_reg;
    logic [7:0]  o_rd_reg, o_ri_reg, o_err_reg;

    logic        acc;
    logic        beg;
    logic        rv;
    logic [7:0]  rdat, ridx;
    logic [1:0]  err_inc;
    logic [8:0]  err_sum;
    logic [15:0] wc_inc;
    logic        s_ready;
    logic        s_err;
    logic        rx;
    logic        ack_lvl;
    logic        byte_done;
    logic [8:0]  pos_inc;
    logic [1:0]  status;
    logic [7:0]  buf_data;
    buf_req_t    breq;

    assign in_ready = !ov_reg || out_ready;
    assign acc      = in_valid && in_ready;
    assign pos_inc  = {1'b0, pos_reg} + 9'd1;
    assign wc_inc   = (wait_reg == 16'hFFFF) ? wait_reg : wait_reg + 16'd1;
    // released SCL counts as high once the stretch limit is reached
    assign s_ready  = scl_in || (wc_inc >= stretch_reg);
    assign s_err    = !scl_in && (wc_inc >= stretch_reg);
    assign rx       = (phase_reg == PH_RDATA);
    assign ack_lvl  = (pos_inc < {1'b0, req_bc_reg}) ? 1'b0 : 1'b1;

    i2cmrt_wbuf #(.BUF_DEPTH(BUF_DEPTH)) u_wbuf
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (breq),
        .rdata (buf_data)
    );

    always_comb
    begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        pos_next     = pos_reg;
        wait_next    = wait_reg;
        req_sa_next  = req_sa_reg;
        req_ra_next  = req_ra_reg;
        req_two_next = req_two_reg;
        req_bc_next  = req_bc_reg;
        req_rd_next  = req_rd_reg;
        power_next   = power_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        err_inc      = 2'd0;
        beg          = 1'b0;
        rv           = 1'b0;
        rdat         = 8'd0;
        ridx         = 8'd0;
        byte_done    = 1'b0;
        breq.we      = 1'b0;
        breq.waddr   = write_index;
        breq.wdata   = write_byte;
        err_next     = err_reg;

        if (acc)
        begin
            case (opcode)
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_INIT, PH_STOP:
                        begin
                            if (slot_reg == 3'd0)
                            begin
                                scl_next  = 1'b0;
                                sda_next  = 1'b0;
                                slot_next = 3'd1;
                            end
                            else if (slot_reg == 3'd1)
                            begin
                                scl_next  = 1'b1;
                                wait_next = 16'd0;
                                slot_next = 3'd2;
                            end
                            else if (slot_reg == 3'd2)
                            begin
                                if (!scl_in)
                                begin
                                    wait_next = wc_inc;
                                end
                                err_inc = {1'b0, s_err};
                                if (s_ready)
                                begin
                                    slot_next = 3'd3;
                                end
                            end
                            else
                            begin
                                sda_next   = 1'b1;
                                slot_next  = 3'd0;
                                wait_next  = 16'd0;
                                phase_next = (phase_reg == PH_INIT) ? PH_IDLE : PH_PAUSE;
                            end
                        end
                        PH_START:
                        begin
                            if (slot_reg == 3'd0)
                            begin
                                power_next = scl_in & sda_in;
                                scl_next   = 1'b1;
                                sda_next   = 1'b1;
                                slot_next  = 3'd1;
                            end
                            else if (slot_reg == 3'd1)
                            begin
                                sda_next  = 1'b0;
                                slot_next = 3'd2;
                            end
                            else
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_ADDR;
                                shift_next = req_sa_reg;
                                bit_next   = 4'd0;
                                slot_next  = 3'd0;
                            end
                        end
                        PH_RESTART:
                        begin
                            if (slot_reg == 3'd0)
                            begin
                                sda_next  = 1'b1;
                                slot_next = 3'd1;
                            end
                            else if (slot_reg == 3'd1)
                            begin
                                scl_next  = 1'b1;
                                wait_next = 16'd0;
                                slot_next = 3'd2;
                            end
                            else if (slot_reg == 3'd2)
                            begin
                                if (!scl_in)
                                begin
                                    wait_next = wc_inc;
                                end
                                err_inc = {1'b0, s_err};
                                if (s_ready)
                                begin
                                    slot_next = 3'd3;
                                end
                            end
                            else if (slot_reg == 3'd3)
                            begin
                                sda_next  = 1'b0;
                                slot_next = 3'd4;
                            end
                            else
                            begin
                                scl_next   = 1'b0;
                                phase_next = PH_RADDR;
                                shift_next = req_sa_reg | 8'h01;
                                bit_next   = 4'd0;
                                slot_next  = 3'd0;
                            end
                        end
                        PH_ADDR, PH_REGH, PH_REGL, PH_RADDR, PH_WDATA, PH_RDATA:
                        begin
                            case (slot_reg)
                                3'd0:
                                begin
                                    if (!bit_reg[3])
                                    begin
                                        sda_next = rx ? 1'b1 : shift_reg[~bit_reg[2:0]];
                                    end
                                    else
                                    begin
                                        sda_next = rx ? ack_lvl : 1'b1;
                                    end
                                    slot_next = 3'd1;
                                end
                                3'd1:
                                begin
                                    scl_next  = 1'b1;
                                    wait_next = 16'd0;
                                    slot_next = 3'd2;
                                end
                                3'd2:
                                begin
                                    if (!scl_in)
                                    begin
                                        wait_next = wc_inc;
                                    end
                                    if (s_ready)
                                    begin
                                        if (!bit_reg[3])
                                        begin
                                            if (rx)
                                            begin
                                                shift_next = {shift_reg[6:0], sda_in};
                                            end
                                            err_inc = {1'b0, s_err};
                                        end
                                        else
                                        begin
                                            // NACK on a sent byte counts too
                                            err_inc = 2'(s_err) + 2'(!rx && sda_in);
                                        end
                                        slot_next = 3'd3;
                                    end
                                end
                                default:
                                begin
                                    scl_next  = 1'b0;
                                    slot_next = 3'd0;
                                    if (bit_reg >= 4'd8)
                                    begin
                                        bit_next  = 4'd0;
                                        byte_done = 1'b1;
                                    end
                                    else
                                    begin
                                        bit_next = bit_reg + 4'd1;
                                    end
                                end
                            endcase

                            if (byte_done)
                            begin
                                case (phase_reg)
                                    PH_RDATA:
                                    begin
                                        rv       = 1'b1;
                                        rdat     = shift_reg;
                                        ridx     = pos_reg;
                                        pos_next = pos_inc[7:0];
                                        if (pos_inc >= {1'b0, req_bc_reg})
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                        else
                                        begin
                                            shift_next = 8'd0;
                                        end
                                    end
                                    PH_ADDR:
                                    begin
                                        if (req_bc_reg == 8'd0)
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                        else if (req_two_reg)
                                        begin
                                            phase_next = PH_REGH;
                                            shift_next = req_ra_reg[15:8];
                                        end
                                        else
                                        begin
                                            phase_next = PH_REGL;
                                            shift_next = req_ra_reg[7:0];
                                        end
                                    end
                                    PH_REGH:
                                    begin
                                        phase_next = PH_REGL;
                                        shift_next = req_ra_reg[7:0];
                                    end
                                    PH_REGL:
                                    begin
                                        if (req_rd_reg)
                                        begin
                                            phase_next = PH_RESTART;
                                        end
                                        else
                                        begin
                                            phase_next = PH_WDATA;
                                            shift_next = buf_data;
                                        end
                                    end
                                    PH_RADDR:
                                    begin
                                        phase_next = PH_RDATA;
                                        shift_next = 8'd0;
                                    end
                                    default:
                                    begin
                                        pos_next = pos_inc[7:0];
                                        if (pos_inc >= {1'b0, req_bc_reg})
                                        begin
                                            phase_next = PH_STOP;
                                        end
                                        else
                                        begin
                                            shift_next = buf_data;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_PAUSE:
                        begin
                            power_next = scl_in & sda_in;
                            if (wait_reg >= pause_reg)
                            begin
                                phase_next = (err_reg != 8'd0) ? PH_DONE_ERR : PH_DONE_OK;
                            end
                            else
                            begin
                                wait_next = wait_reg + 16'd1;
                            end
                        end
                        default:
                        begin
                            power_next = scl_in & sda_in;
                        end
                    endcase
                    if (phase_next == PH_INIT)
                    begin
                        power_next = 1'b1;
                    end
                end
                OP_BEGIN:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        req_sa_next  = slave_addr;
                        req_ra_next  = reg_addr;
                        req_two_next = reg_addr_two;
                        req_bc_next  = byte_count;
                        req_rd_next  = is_read;
                        pos_next     = 8'd0;
                        bit_next     = 4'd0;
                        slot_next    = 3'd0;
                        phase_next   = PH_START;
                        beg          = 1'b1;
                    end
                end
                OP_LOAD:
                begin
                    breq.we = 1'b1;
                end
                default:
                begin
                    if (phase_reg == PH_DONE_OK || phase_reg == PH_DONE_ERR)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            endcase
        end

        err_sum = {1'b0, err_reg} + 9'(err_inc);
        if (beg)
        begin
            err_next = 8'd0;
        end
        else if (err_sum[8])
        begin
            err_next = 8'hFF;
        end
        else
        begin
            err_next = err_sum[7:0];
        end

        // prefetch the next position to be sent
        breq.raddr = (phase_next == PH_WDATA) ? ({1'b0, pos_next} + 9'd1) : {1'b0, pos_next};

        case (phase_next)
            PH_IDLE, PH_INIT: status = ST_IDLE;
            PH_DONE_OK:       status = ST_DONE_OK;
            PH_DONE_ERR:      status = ST_DONE_ERR;
            default:          status = ST_BUSY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_reg   <= PAUSE_RESET;
            stretch_reg <= STRETCH_RESET;
            phase_reg   <= PH_INIT;
            slot_reg    <= 3'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            pos_reg     <= 8'd0;
            err_reg     <= 8'd0;
            wait_reg    <= 16'd0;
            req_sa_reg  <= 8'd0;
            req_ra_reg  <= 16'd0;
            req_two_reg <= 1'b0;
            req_bc_reg  <= 8'd0;
            req_rd_reg  <= 1'b0;
            power_reg   <= 1'b1;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PAUSE: pause_reg   <= cfg_data;
                    default:   stretch_reg <= cfg_data;
                endcase
            end
            phase_reg   <= phase_next;
            slot_reg    <= slot_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            pos_reg     <= pos_next;
            err_reg     <= err_next;
            wait_reg    <= wait_next;
            req_sa_reg  <= req_sa_next;
            req_ra_reg  <= req_ra_next;
            req_two_reg <= req_two_next;
            req_bc_reg  <= req_bc_next;
            req_rd_reg  <= req_rd_next;
            power_reg   <= power_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            if (acc)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            o_scl_reg <= scl_next;
            o_sda_reg <= sda_next;
            o_st_reg  <= status;
            o_beg_reg <= beg;
            o_rv_reg  <= rv;
            o_rd_reg  <= rdat;
            o_ri_reg  <= ridx;
            o_err_reg <= err_next;
            o_pw_reg  <= power_next;
        end
    end

    assign out_valid      = ov_reg;
    assign scl_drive      = o_scl_reg;
    assign sda_drive      = o_sda_reg;
    assign bus_status     = o_st_reg;
    assign begin_accepted = o_beg_reg;
    assign read_valid     = o_rv_reg;
    assign read_data      = o_rd_reg;
    assign read_index     = o_ri_reg;
    assign error_count    = o_err_reg;
    assign line_power     = o_pw_reg;

endmodule

>>> verif/tb_i2c_master_register_transfer.sv
`timescale 1ns / 1ps
// Self-checking testbench for the I2C register transfer master.
module tb_i2c_master_register_transfer;
    import i2cmrt_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [1:0] status;
        logic       accepted;
        logic       rvalid;
        logic [7:0] rdata;
        logic [7:0] rindex;
        logic [7:0] errs;
        logic       power;
    } status_word_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic        scl_in;
    logic        sda_in;
    logic [7:0]  slave_addr;
    logic [15:0] reg_addr;
    logic        reg_addr_two;
    logic [7:0]  byte_count;
    logic        is_read;
    logic [7:0]  write_index;
    logic [7:0]  write_byte;
    logic        out_valid;
    logic        out_ready;
    logic        scl_drive;
    logic        sda_drive;
    logic [1:0]  bus_status;
    logic        begin_accepted;
    logic        read_valid;
    logic [7:0]  read_data;
    logic [7:0]  read_index;
    logic [7:0]  error_count;
    logic        line_power;

    i2c_master_register_transfer dut (.*);

    // predicted sequencer state
    phase_t      seq_phase;
    int          seq_slot;
    int          seq_bit;
    logic [7:0]  seq_shift;
    int          seq_pos;
    logic [7:0]  seq_errs;
    logic [15:0] seq_wait;
    logic [7:0]  req_slave;
    logic [15:0] req_reg;
    logic        req_two;
    logic [7:0]  req_count;
    logic        req_read;
    logic [7:0]  tx_buffer [256];
    logic        seq_power;
    logic        seq_scl;
    logic        seq_sda;
    logic [15:0] pause_len;
    logic [15:0] stretch_len;

    status_word_t expected_words[$];
    int  mismatches;
    int  words_checked;
    int  transfers_done;
    int  random_words;
    int  hold_left;
    int  stall_left;
    int  ready_pct;
    int  long_gap_pct;
    int  scl_low_pct;
    int  reads_seen;

    function automatic void bump_errors();
        if (seq_errs != 8'hFF) seq_errs++;
    endfunction

    function automatic bit scl_released(logic scl);
        if (scl) return 1'b1;
        if (seq_wait != 16'hFFFF) seq_wait++;
        if (seq_wait >= stretch_len) begin
            bump_errors();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void start_byte(phase_t nxt, logic [7:0] value);
        seq_phase = nxt;
        seq_shift = value;
        seq_bit   = 0;
        seq_slot  = 0;
    endfunction

    function automatic void to_stop();
        seq_phase = PH_STOP;
        seq_slot  = 0;
    endfunction

    // one tick of a byte; true when the ACK bit finishes
    function automatic bit bit_tick(bit rx, logic ack, logic scl, logic sda);
        case (seq_slot)
            0: begin
                if (seq_bit < 8) seq_sda = rx ? 1'b1 : seq_shift[7 - seq_bit];
                else             seq_sda = rx ? ack : 1'b1;
                seq_slot = 1;
            end
            1: begin
                seq_scl  = 1'b1;
                seq_wait = '0;
                seq_slot = 2;
            end
            2: begin
                if (scl_released(scl)) begin
                    if (seq_bit < 8) begin
                        if (rx) seq_shift = {seq_shift[6:0], sda};
                    end else if (!rx && sda) begin
                        bump_errors();
                    end
                    seq_slot = 3;
                end
            end
            default: begin
                seq_scl  = 1'b0;
                seq_slot = 0;
                if (seq_bit >= 8) begin
                    seq_bit = 0;
                    return 1'b1;
                end
                seq_bit++;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void next_after_tx();
        case (seq_phase)
            PH_ADDR: begin
                if (req_count == 0) to_stop();
                else if (req_two) start_byte(PH_REGH, req_reg[15:8]);
                else start_byte(PH_REGL, req_reg[7:0]);
            end
            PH_REGH: start_byte(PH_REGL, req_reg[7:0]);
            PH_REGL: begin
                if (req_read) begin
                    seq_phase = PH_RESTART;
                    seq_slot  = 0;
                end else begin
                    start_byte(PH_WDATA, tx_buffer[seq_pos]);
                end
            end
            PH_RADDR: start_byte(PH_RDATA, 8'h00);
            default: begin
                seq_pos++;
                if (seq_pos >= req_count) to_stop();
                else start_byte(PH_WDATA, tx_buffer[seq_pos]);
            end
        endcase
    endfunction

    function automatic void bus_tick(logic scl, logic sda, ref status_word_t w);
        logic ack;
        case (seq_phase)
            PH_INIT, PH_STOP: begin
                if (seq_slot == 0) begin
                    seq_scl = 1'b0; seq_sda = 1'b0; seq_slot = 1;
                end else if (seq_slot == 1) begin
                    seq_scl = 1'b1; seq_wait = '0; seq_slot = 2;
                end else if (seq_slot == 2) begin
                    if (scl_released(scl)) seq_slot = 3;
                end else begin
                    seq_sda   = 1'b1;
                    seq_slot  = 0;
                    seq_wait  = '0;
                    seq_phase = (seq_phase == PH_INIT) ? PH_IDLE : PH_PAUSE;
                end
            end
            PH_START: begin
                if (seq_slot == 0) begin
                    seq_power = scl & sda;
                    seq_scl = 1'b1; seq_sda = 1'b1; seq_slot = 1;
                end else if (seq_slot == 1) begin
                    seq_sda = 1'b0; seq_slot = 2;
                end else begin
                    seq_scl = 1'b0;
                    start_byte(PH_ADDR, req_slave);
                end
            end
            PH_RESTART: begin
                if (seq_slot == 0) begin
                    seq_sda = 1'b1; seq_slot = 1;
                end else if (seq_slot == 1) begin
                    seq_scl = 1'b1; seq_wait = '0; seq_slot = 2;
                end else if (seq_slot == 2) begin
                    if (scl_released(scl)) seq_slot = 3;
                end else if (seq_slot == 3) begin
                    seq_sda = 1'b0; seq_slot = 4;
                end else begin
                    seq_scl = 1'b0;
                    start_byte(PH_RADDR, req_slave | 8'h01);
                end
            end
            PH_ADDR, PH_REGH, PH_REGL, PH_RADDR, PH_WDATA: begin
                if (bit_tick(1'b0, 1'b1, scl, sda)) next_after_tx();
            end
            PH_RDATA: begin
                ack = (seq_pos + 1 < req_count) ? 1'b0 : 1'b1;
                if (bit_tick(1'b1, ack, scl, sda)) begin
                    w.rvalid = 1'b1;
                    w.rdata  = seq_shift;
                    w.rindex = seq_pos[7:0];
                    seq_pos++;
                    if (seq_pos >= req_count) to_stop();
                    else start_byte(PH_RDATA, 8'h00);
                end
            end
            PH_PAUSE: begin
                seq_power = scl & sda;
                if (seq_wait >= pause_len)
                    seq_phase = (seq_errs != 0) ? PH_DONE_ERR : PH_DONE_OK;
                else
                    seq_wait++;
            end
            default: seq_power = scl & sda;
        endcase
        if (seq_phase == PH_INIT) seq_power = 1'b1;
    endfunction

    function automatic status_word_t predict_status();
        status_word_t w;
        w = '0;
        case (opcode)
            OP_TICK: bus_tick(scl_in, sda_in, w);
            OP_BEGIN: begin
                if (seq_phase == PH_IDLE) begin
                    req_slave = slave_addr;
                    req_reg   = reg_addr;
                    req_two   = reg_addr_two;
                    req_count = byte_count;
                    req_read  = is_read;
                    seq_errs  = '0;
                    seq_pos   = 0;
                    seq_bit   = 0;
                    seq_slot  = 0;
                    seq_phase = PH_START;
                    w.accepted = 1'b1;
                end
            end
            OP_LOAD: tx_buffer[write_index] = write_byte;
            default: if (seq_phase inside {PH_DONE_OK, PH_DONE_ERR}) seq_phase = PH_IDLE;
        endcase
        if (seq_phase inside {PH_IDLE, PH_INIT}) w.status = ST_IDLE;
        else if (seq_phase == PH_DONE_OK)      w.status = ST_DONE_OK;
        else if (seq_phase == PH_DONE_ERR)     w.status = ST_DONE_ERR;
        else                                   w.status = ST_BUSY;
        w.scl   = seq_scl;
        w.sda   = seq_sda;
        w.errs  = seq_errs;
        w.power = seq_power;
        return w;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Timeout waiting for status words");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < ready_pct) begin
            out_ready <= 1'b1;
        end else begin
            out_ready  <= 1'b0;
            stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(0, 2);
        end
    end

    // scoreboard: words accepted at the coming rising edge are checked on the falling edge before it
    always @(negedge clk)
    begin
        status_word_t exp_w, got;
        if (rst_n && out_valid && out_ready) begin
            got = {scl_drive, sda_drive, bus_status, begin_accepted, read_valid,
                   read_data, read_index, error_count, line_power};
            words_checked++;
            if (got.rvalid) reads_seen++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected status word %h", got);
            end else begin
                exp_w = expected_words.pop_front();
                if (got !== exp_w) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"Word %0d: expected scl %b sda %b st %0d acc %b rv %b",
                                  " rd %h ri %0d err %0d pw %b"},
                                 words_checked, exp_w.scl, exp_w.sda, exp_w.status,
                                 exp_w.accepted, exp_w.rvalid, exp_w.rdata, exp_w.rindex,
                                 exp_w.errs, exp_w.power);
                        $display({"         got      scl %b sda %b st %0d acc %b rv %b",
                                  " rd %h ri %0d err %0d pw %b"},
                                 got.scl, got.sda, got.status,
                                 got.accepted, got.rvalid, got.rdata, got.rindex,
                                 got.errs, got.power);
                    end
                end
            end
        end
    end

    // offer one word, wait for acceptance, record its predicted status
    task automatic send_word(logic [1:0] op, logic scl, logic sda, logic [7:0] sa,
                             logic [15:0] ra, logic two, logic [7:0] cnt, logic rd,
                             logic [7:0] widx, logic [7:0] wb);
        int gap;
        opcode       <= op;
        scl_in       <= scl;
        sda_in       <= sda;
        slave_addr   <= sa;
        reg_addr     <= ra;
        reg_addr_two <= two;
        byte_count   <= cnt;
        is_read      <= rd;
        write_index  <= widx;
        write_byte   <= wb;
        in_valid     <= 1'b1;
        forever begin
            @(negedge clk);
            if (in_ready) break;
        end
        @(posedge clk);
        expected_words.push_back(predict_status());
        random_words++;
        gap = 0;
        if ($urandom_range(0, 99) < long_gap_pct)
            gap = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic tick(logic scl, logic sda);
        send_word(OP_TICK, scl, sda, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    task automatic random_tick();
        tick(($urandom_range(0, 99) >= scl_low_pct), $urandom_range(0, 1));
    endtask

    task automatic wait_idle_bus();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        wait_idle_bus();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_PAUSE) pause_len = value;
        else stretch_len = value;
    endtask

    task automatic tick_until_idle();
        while (seq_phase != PH_IDLE) random_tick();
    endtask

    // load the bytes it sends, start it, tick to completion, then clear
    task automatic run_transfer(logic [7:0] sa, logic [15:0] ra, logic two,
                                logic [7:0] cnt, logic rd);
        if (!rd)
            for (int i = 0; i < cnt; i++)
                send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, i[7:0], $urandom);
        send_word(OP_BEGIN, $urandom, $urandom, sa, ra, two, cnt, rd, $urandom, $urandom);
        while (!(seq_phase inside {PH_DONE_OK, PH_DONE_ERR})) begin
            random_tick();
            // stray requests while busy must be ignored
            if ($urandom_range(0, 149) == 0 &&
                !(seq_phase inside {PH_DONE_OK, PH_DONE_ERR}))
                send_word($urandom_range(0, 1) ? OP_BEGIN : OP_CLEAR, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom);
        end
        if ($urandom_range(0, 3) == 0) random_tick();
        send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
        transfers_done++;
    endtask

    task automatic test_directed();
        scl_low_pct = 0;
        write_reg(CFG_PAUSE, 16'd0);
        write_reg(CFG_STRETCH, 16'd1);
        tick_until_idle();
        // clear and load outside a transfer; begin rejected nowhere yet
        send_word(OP_CLEAR, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_LOAD, 1, 1, 0, 0, 0, 0, 0, 8'd255, 8'hA5);
        run_transfer(8'hFE, 16'hFFFF, 1'b1, 8'd2, 1'b0);
        run_transfer(8'h00, 16'h0000, 1'b0, 8'd1, 1'b1);
        run_transfer(8'hA0, 16'h1234, 1'b0, 8'd0, 1'b1);
        run_transfer(8'h42, 16'h8001, 1'b1, 8'd3, 1'b1);
    endtask

    task automatic test_stretch_timeout();
        write_reg(CFG_STRETCH, 16'd3);
        scl_low_pct = 40;
        run_transfer($urandom, $urandom, 1'b1, 8'd2, 1'b0);
        run_transfer($urandom, $urandom, 1'b0, 8'd2, 1'b1);
        scl_low_pct = 0;
    endtask

    task automatic test_extreme_settings();
        write_reg(CFG_PAUSE, 16'd300);
        write_reg(CFG_STRETCH, 16'hFFFF);
        scl_low_pct = 5;
        run_transfer($urandom, $urandom, 1'b0, 8'd0, 1'b0);
        write_reg(CFG_PAUSE, 16'd0);
        write_reg(CFG_STRETCH, 16'd1);
        scl_low_pct = 3;
        run_transfer($urandom, $urandom, 1'b1, 8'd12, 1'b1);
    endtask

    task automatic test_random();
        random_words = 0;
        while (random_words < 1600) begin
            if ($urandom_range(0, 2) == 0) begin
                write_reg(CFG_PAUSE, $urandom_range(0, 30));
                write_reg(CFG_STRETCH, ($urandom_range(0, 5) == 0) ? 16'hFFFF
                                                                   : $urandom_range(1, 8));
            end
            scl_low_pct  = $urandom_range(0, 30);
            long_gap_pct = $urandom_range(0, 1) ? 0 : 30;
            ready_pct    = $urandom_range(0, 1) ? 100 : 75;
            // some idle noise between transfers
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(0, 2))
                    0: random_tick();
                    1: send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom, $urandom, $urandom);
                    default: send_word(OP_LOAD, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom, $urandom);
                endcase
            end
            run_transfer($urandom, $urandom, $urandom, $urandom_range(0, 5),
                         $urandom_range(0, 1));
        end
    endtask

    task automatic test_backpressure();
        long_gap_pct = 0;
        in_valid <= 1'b0;
        @(negedge clk);
        hold_left = 300;
        @(posedge clk);
        run_transfer($urandom, $urandom, 1'b1, 8'd4, 1'b0);
        // sender waits until all status words are back
        wait_idle_bus();
        run_transfer($urandom, $urandom, 1'b0, 8'd2, 1'b1);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_PAUSE;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        opcode       <= OP_TICK;
        scl_in       <= 1'b1;
        sda_in       <= 1'b1;
        slave_addr   <= '0;
        reg_addr     <= '0;
        reg_addr_two <= 1'b0;
        byte_count   <= '0;
        is_read      <= 1'b0;
        write_index  <= '0;
        write_byte   <= '0;
        out_ready    <= 1'b0;
        hold_left    = 0;
        stall_left   = 0;
        ready_pct    = 80;
        long_gap_pct = 20;
        scl_low_pct  = 0;
        mismatches   = 0;
        words_checked = 0;
        transfers_done = 0;
        reads_seen   = 0;
        seq_phase    = PH_INIT;
        seq_slot     = 0;
        seq_bit      = 0;
        seq_shift    = '0;
        seq_pos      = 0;
        seq_errs     = '0;
        seq_wait     = '0;
        {req_slave, req_reg, req_two, req_count, req_read} = '0;
        seq_power    = 1'b1;
        seq_scl      = 1'b1;
        seq_sda      = 1'b1;
        pause_len    = PAUSE_RESET;
        stretch_len  = STRETCH_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_stretch_timeout();
        test_extreme_settings();
        test_backpressure();
        test_random();

        wait_idle_bus();
        repeat (20) @(posedge clk);
        $display("Covered %0d transfers, %0d status words, %0d read bytes;",
                 transfers_done, words_checked, reads_seen);
        $display("writes, reads, address-only, stretch timeouts, long pause and stall.");
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/i2cmrt_pkg.sv
hw/rtl/i2cmrt_wbuf.sv
hw/rtl/i2c_master_register_transfer.sv
verif/tb_i2c_master_register_transfer.sv
